FILE: design/bse_pkg.sv
// Shared constants and types for the bubble sort engine.
package bse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int DATA_W       = 32;
  localparam int CMP_W        = 11;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CMP_W-1:0] cmp_cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_FIRST,
    S_CMP,
    S_END,
    S_EMIT
  } bse_state_t;

endpackage

FILE: design/bubble_sort_engine.sv
// Top level of the bubble sort engine: load, sort and emit sequencer around one RAM.
//
// Usage:
//   Input: one transaction per element, taken at a rising edge with start high and
//   busy low. in_is_final_element closes the set; the element that brings the set
//   to MAX_ELEMENTS closes it as well, and the next element opens a new set.
//   A non-final element leaves busy low.
//   Sort: the closing element raises busy. One compare unit walks the store, one
//   adjacent pair per cycle, carrying the larger value forward in a register, so
//   the RAM sees one read and one write per cycle. Each pass reads the first element
//   (S_RD0, S_FIRST), compares each pair (S_CMP) and writes the carried value (S_END);
//   after the last pass, the sorted set is emitted.
//   Output: n result transactions on consecutive cycles, each marked by a one-cycle
//   out_valid strobe, the last with out_is_final_result. The receiver cannot stall;
//   results are dropped if not taken. busy falls as the final result is shown, so
//   the next set may start loading in that cycle.
//   Reset: rst_n (synchronous, active low) clears the sequencer, the element count
//   and the compare count. Store contents are not cleared; only entries written for
//   the current set are ever read.
module bubble_sort_engine
  import bse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_element_value,
  input  logic                     in_is_final_element,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_is_final_result,
  output logic [CMP_W-1:0]         out_compare_count
);

  bse_state_t  state_r, state_nxt;
  idx_t        count_r, count_nxt;     // elements held for the open set
  idx_t        lim_r, lim_nxt;         // last index of the current pass
  idx_t        last_r, last_nxt;       // last index of the set, used for emission
  idx_t        j_r, j_nxt;             // index of the element under compare
  idx_t        k_r, k_nxt;             // emission read index
  cmp_cnt_t    total_r, total_nxt;
  logic [DATA_W-1:0] carry_r, carry_nxt;
  logic        emit_v_r, emit_v_nxt;
  logic        emit_last_r, emit_last_nxt;

  // RAM port controls
  logic              ram_we;
  idx_t              ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  idx_t              ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic accept;
  logic is_less;

  bse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  // The single shared compare: fresh element against the carried one.
  assign is_less = $signed(ram_rdata) < $signed(carry_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lim_nxt       = lim_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    total_nxt     = total_r;
    carry_nxt     = carry_r;
    emit_v_nxt    = 1'b0;
    emit_last_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = count_r;
    ram_wdata     = in_element_value;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ram_we    = 1'b1;
          ram_waddr = count_r;
          ram_wdata = in_element_value;
          if (in_is_final_element || (count_r == idx_t'(MAX_ELEMENTS - 1))) begin
            // Set closed: n = count_r + 1.
            count_nxt = '0;
            lim_nxt   = count_r;
            last_nxt  = count_r;
            total_nxt = '0;
            k_nxt     = '0;
            state_nxt = (count_r == '0) ? S_EMIT : S_RD0;
          end else begin
            count_nxt = count_r + idx_t'(1);
          end
        end
      end

      S_RD0: begin
        ram_raddr = '0;
        state_nxt = S_FIRST;
      end

      S_FIRST: begin
        carry_nxt = ram_rdata;
        ram_raddr = idx_t'(1);
        j_nxt     = idx_t'(1);
        state_nxt = S_CMP;
      end

      S_CMP: begin
        total_nxt = total_r + cmp_cnt_t'(1);
        ram_we    = 1'b1;
        ram_waddr = j_r - idx_t'(1);
        if (is_less) begin
          ram_wdata = ram_rdata;     // swap: smaller value moves down
        end else begin
          ram_wdata = carry_r;
          carry_nxt = ram_rdata;     // larger value travels on
        end
        if (j_r == lim_r) begin
          state_nxt = S_END;
        end else begin
          ram_raddr = j_r + idx_t'(1);
          j_nxt     = j_r + idx_t'(1);
        end
      end

      S_END: begin
        ram_we    = 1'b1;
        ram_waddr = lim_r;
        ram_wdata = carry_r;
        if (lim_r == idx_t'(1)) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          lim_nxt   = lim_r - idx_t'(1);
          state_nxt = S_RD0;
        end
      end

      S_EMIT: begin
        ram_raddr     = k_r;
        emit_v_nxt    = 1'b1;
        emit_last_nxt = (k_r == last_r);
        if (k_r == last_r) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + idx_t'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      emit_v_r    <= 1'b0;
      emit_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      emit_v_r    <= emit_v_nxt;
      emit_last_r <= emit_last_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    lim_r   <= lim_nxt;
    last_r  <= last_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    carry_r <= carry_nxt;
  end

  // Read data lands in the cycle after the emission read, in step with the strobe.
  assign out_valid           = emit_v_r;
  assign out_sorted_value    = $signed(ram_rdata);
  assign out_is_final_result = emit_last_r;
  assign out_compare_count   = total_r;

endmodule

FILE: design/bse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bse_chk.sv
// Port-level checker for the bubble sort engine, bound to the top level.
module bse_chk
  import bse_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_is_final_element,
  input logic             out_valid,
  input logic             out_is_final_result,
  input logic [CMP_W-1:0] out_compare_count
);

  // A result only follows a busy cycle.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result shown without preceding busy cycle");

  a_final_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_is_final_result |-> out_valid)
    else $error("final mark without result strobe");

  a_gap_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_final_result) |=> !out_valid)
    else $error("result strobe right after final result");

  // A set's results come back to back with one compare count.
  a_burst_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_final_result) |=> (out_valid && $stable(out_compare_count)))
    else $error("result burst broken or compare count changed");

  a_final_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_is_final_element) |=> busy)
    else $error("closing transaction did not raise busy");

endmodule

bind bubble_sort_engine bse_chk u_bse_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_is_final_element (in_is_final_element),
  .out_valid           (out_valid),
  .out_is_final_result (out_is_final_result),
  .out_compare_count   (out_compare_count)
);

FILE: test/tb_top.sv
// Self-checking testbench for the bubble sort engine: element sets in, sorted streams checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 390;   // plus the directed sets, about 410 in all
  localparam int unsigned SETTLE_CYCLES = 2400;  // longer than one full-set sort and drain
  localparam int unsigned TIMEOUT_NS = 3_000_000;

  // One expected output transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    cmp_cnt_t                 compares;
  } sorted_word_t;

  // Holds the open set as the block sees it, sorts it when the set closes,
  // and queues the sorted stream for the output checker.
  class sorted_set_board;
    logic signed [DATA_W-1:0] open_set[$];
    sorted_word_t             pending_sorted[$];
    int unsigned              mismatches = 0;

    // Called once per accepted input transaction.
    function void take_element(logic signed [DATA_W-1:0] v, logic fin);
      logic signed [DATA_W-1:0] held;
      cmp_cnt_t                 compares;
      sorted_word_t             w;
      int                       n;
      open_set.push_back(v);
      // a set closes on the final flag or when it fills the store
      if (!fin && open_set.size() < MAX_ELEMENTS) return;
      n = open_set.size();
      compares = '0;
      for (int p = 0; p < n - 1; p++) begin
        for (int j = 1; j < n - p; j++) begin
          compares++;
          if (open_set[j] < open_set[j-1]) begin
            held          = open_set[j-1];
            open_set[j-1] = open_set[j];
            open_set[j]   = held;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        w.value    = open_set[k];
        w.last     = (k == n - 1);
        w.compares = compares;
        pending_sorted.push_back(w);
      end
      open_set.delete();
    endfunction

    // Called once per output strobe.
    function void check_output(logic signed [DATA_W-1:0] value, logic last,
                               cmp_cnt_t compares);
      sorted_word_t want;
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0d last %0b count %0d",
                 $time, value, last, compares);
        mismatches++;
        return;
      end
      want = pending_sorted.pop_front();
      if (value !== want.value) begin
        $display("%0t: sorted_value expected %0d actual %0d", $time, want.value, value);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: is_final_result expected %0b actual %0b", $time, want.last, last);
        mismatches++;
      end
      if (compares !== want.compares) begin
        $display("%0t: compare_count expected %0d actual %0d", $time, want.compares, compares);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     in_is_final_element = 1'b0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_is_final_result;
  logic [CMP_W-1:0]         out_compare_count;

  sorted_set_board sb = new();

  bubble_sort_engine u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_element_value    (in_element_value),
    .in_is_final_element (in_is_final_element),
    .out_valid           (out_valid),
    .out_sorted_value    (out_sorted_value),
    .out_is_final_result (out_is_final_result),
    .out_compare_count   (out_compare_count)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // Result side: the receiver cannot stall, so every strobe is a transaction.
  // Sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_output(out_sorted_value, out_is_final_result, out_compare_count);
    end
  end

  // Hard stop in case the block hangs or never drains.
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // One input transaction. The gap is spent with start low; then start is raised
  // at a falling edge and held until a rising edge sees busy low. Back-to-back
  // calls with no gap keep start high, so it is never dropped and re-raised.
  task automatic send_element(input logic signed [DATA_W-1:0] v, input logic fin,
                              input int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start               = 1'b1;
    in_element_value    = v;
    in_is_final_element = fin;
    do @(posedge clk); while (busy);
    sb.take_element(v, fin);
  endtask

  // Hold off the sender until every queued result has come out.
  // start drops first so the last element is not taken a second time.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_sorted.size() != 0) @(negedge clk);
  endtask

  // Element values: plenty of duplicates and extremes next to full-range noise.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1: return $signed($urandom_range(0, 6)) - 3;
      2:    return 32'sh7FFF_FFFF;
      3:    return 32'sh8000_0000;
      4:    return -1;
      default: return $urandom;
    endcase
  endfunction

  // Main stimulus thread
  initial begin
    int unsigned sent;
    int unsigned set_size;
    int unsigned pick;
    bit          no_idle;
    logic        fin;

    // synchronous reset, held low first, then released
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // --- directed sets ---
    // single-element sets at both extremes: no pass, zero compares
    send_element(32'sh7FFF_FFFF, 1'b1, 0);
    send_element(32'sh8000_0000, 1'b1, 0);
    // pair that needs a swap across the sign boundary
    send_element(32'sh7FFF_FFFF, 1'b0, 0);
    send_element(32'sh8000_0000, 1'b1, 1);
    // duplicates around zero
    send_element(-1, 1'b0, 0);
    send_element(0, 1'b0, 2);
    send_element(-1, 1'b1, 0);
    // strictly descending, extremes included: every compare swaps
    send_element(32'sh7FFF_FFFF, 1'b0, 0);
    send_element(1, 1'b0, 0);
    send_element(0, 1'b0, 3);
    send_element(-1, 1'b0, 0);
    send_element(32'sh8000_0000, 1'b1, 0);
    // already ascending: no swaps at all
    send_element(32'sh8000_0000, 1'b0, 0);
    send_element(-1, 1'b0, 0);
    send_element(0, 1'b0, 0);
    send_element(32'sh7FFF_FFFF, 1'b1, 4);
    // all equal
    send_element(7, 1'b0, 0);
    send_element(7, 1'b0, 0);
    send_element(7, 1'b1, 0);
    // let the whole directed stream come out before going random
    wait_drained();

    // --- random sets ---
    // Mostly short sets; some mid-size; now and then a full store, which
    // closes on its 64th element with or without the final flag (overfull case).
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        set_size = MAX_ELEMENTS;
      end else if (pick < 3) begin
        set_size = $urandom_range(9, 40);
      end else begin
        set_size = $urandom_range(1, 8);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_size; i++) begin
        if (i != set_size - 1) begin
          fin = 1'b0;
        end else if (set_size == MAX_ELEMENTS) begin
          fin = 1'($urandom_range(0, 1));
        end else begin
          fin = 1'b1;
        end
        send_element(pick_value(), fin, no_idle ? 0 : $urandom_range(0, 4));
        sent++;
      end
      // occasional full drain so a set starts on an idle block
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    @(negedge clk);
    start = 1'b0;

    // drain, then allow a full sort's worth of cycles for any stray output
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending_sorted.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
